/* rtl/pcrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrd_pkg
// Shared types and constants for the pinhole camera ray direction block.
// ----------------------------------------------------------------------------
package pcrd_pkg;

	localparam int PIXEL_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 14;
	localparam int IN_PIX_W       = 12;
	localparam int SIZE_W         = 13;
	localparam int TAN_W          = 16;
	localparam int TAN_FRAC       = 12;
	localparam int VEC_W          = 48;
	localparam int LANE_W         = 16;
	localparam int DIR_W          = 16;
	localparam int OUT_FRAC       = 14;
	localparam int NORM_W         = 30;
	localparam int CFG_IDX_W      = 3;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd720;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [TAN_W-1:0]  HTAN_RST   = 16'd1697;
	localparam logic [TAN_W-1:0]  VTAN_RST   = 16'd1131;
	localparam logic [VEC_W-1:0]  UP_RST     = 48'd1073741824;
	localparam logic [VEC_W-1:0]  RIGHT_RST  = 48'd16384;
	localparam logic [VEC_W-1:0]  AIM_RST    = 48'd211106232532992;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_HORIZ_TAN    = 3'd2,
		REG_VERT_TAN     = 3'd3,
		REG_UP_VECTOR    = 3'd4,
		REG_RIGHT_VECTOR = 3'd5,
		REG_AIM_VECTOR   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [IN_PIX_W-1:0] pixel_col;
		logic [IN_PIX_W-1:0] pixel_row;
	} pcrd_in_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
		logic                    zero_length;
	} pcrd_out_t;

endpackage

/* rtl/pcrd_delay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrd_delay
// Register chain that carries side data alongside the arithmetic cells.
// ----------------------------------------------------------------------------
module pcrd_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [DEPTH-1:0][WIDTH-1:0] tap_q;

	always_ff @(posedge clk) begin
		tap_q[0] <= din;
		for (int k = 1; k < DEPTH; k++) begin
			tap_q[k] <= tap_q[k-1];
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

/* rtl/pcrd_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrd_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module pcrd_div_cell #(
	parameter int REM_W = 13,
	parameter int NUM_W = 27,
	parameter int Q_W   = 27
) (
	input  logic             clk,
	input  logic [REM_W-1:0] rem,
	input  logic [NUM_W-1:0] num,
	input  logic [Q_W-1:0]   quo,
	input  logic [REM_W-1:0] den,
	output logic [REM_W-1:0] rem_next,
	output logic [NUM_W-1:0] num_next,
	output logic [Q_W-1:0]   quo_next,
	output logic [REM_W-1:0] den_next
);

	logic [REM_W:0]   trial;
	logic [REM_W:0]   diff;
	logic             take;
	logic [REM_W-1:0] rem_q;
	logic [NUM_W-1:0] num_q;
	logic [Q_W-1:0]   quo_q;
	logic [REM_W-1:0] den_q;

	assign trial = {rem, num[NUM_W-1]};
	assign take  = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk) begin
		rem_q <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
		num_q <= num << 1;
		quo_q <= {quo[Q_W-2:0], take};
		den_q <= den;
	end

	assign rem_next = rem_q;
	assign num_next = num_q;
	assign quo_next = quo_q;
	assign den_next = den_q;

endmodule

/* rtl/pcrd_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrd_sqrt_cell
// One digit-by-digit square root step: one root bit per cell.
// ----------------------------------------------------------------------------
module pcrd_sqrt_cell #(
	parameter int ROOT_W = 31
) (
	input  logic                clk,
	input  logic [2*ROOT_W-1:0] rad,
	input  logic [ROOT_W:0]     rem,
	input  logic [ROOT_W-1:0]   root,
	output logic [2*ROOT_W-1:0] rad_next,
	output logic [ROOT_W:0]     rem_next,
	output logic [ROOT_W-1:0]   root_next
);

	localparam int RAD_W = 2 * ROOT_W;

	logic [ROOT_W+2:0]   trial;
	logic [ROOT_W+2:0]   cand;
	logic [ROOT_W+2:0]   diff;
	logic                take;
	logic [RAD_W-1:0]    rad_q;
	logic [ROOT_W:0]     rem_q;
	logic [ROOT_W-1:0]   root_q;

	assign trial = {rem, rad[RAD_W-1 -: 2]};
	assign cand  = {1'b0, root, 2'b01};
	assign take  = trial >= cand;
	assign diff  = trial - cand;

	always_ff @(posedge clk) begin
		rad_q  <= rad << 2;
		rem_q  <= take ? diff[ROOT_W:0] : trial[ROOT_W:0];
		root_q <= {root[ROOT_W-2:0], take};
	end

	assign rad_next  = rad_q;
	assign rem_next  = rem_q;
	assign root_next = root_q;

endmodule

/* rtl/pcrd_norm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrd_norm_cell
// One stage of the common left shift that brings the largest lane to the top.
// ----------------------------------------------------------------------------
module pcrd_norm_cell #(
	parameter int W  = 50,
	parameter int SH = 1
) (
	input  logic               clk,
	input  logic [W-1:0]       word,
	input  logic [2:0][W-1:0]  mag,
	output logic [W-1:0]       word_next,
	output logic [2:0][W-1:0]  mag_next
);

	logic              hit;
	logic [W-1:0]      word_q;
	logic [2:0][W-1:0] mag_q;

	assign hit = (word[W-1 -: SH] == '0);

	always_ff @(posedge clk) begin
		word_q <= hit ? (word << SH) : word;
		for (int i = 0; i < 3; i++) begin
			mag_q[i] <= hit ? (mag[i] << SH) : mag[i];
		end
	end

	assign word_next = word_q;
	assign mag_next  = mag_q;

endmodule

/* rtl/pinhole_camera_ray_direction.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_camera_ray_direction
// Unit ray direction for a pixel of a pinhole camera.
//
// A pixel (column, row) is taken on a clock edge with start high and busy
// low; busy stays low, so a pixel can be presented on every cycle. The ray
// leaves on ray with done high for exactly one cycle, in the order the
// pixels came in; the receiver takes it on that cycle and cannot stall.
// Throughput is one ray per clock. The pipeline runs through the row of
// division cells for the screen coordinate (one quotient bit each), the
// normalising shift cells, the square root cells (one root bit each) and
// the final division cells. Configuration is written over
// cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; the user must write
// it only while no ray is in flight, which the block itself does not enforce.
// Reset clears the in-flight marks and loads the default camera (720x480,
// up +y, right +x, aim -z); rays in flight at reset are lost, none invented.
// ----------------------------------------------------------------------------
module pinhole_camera_ray_direction
	import pcrd_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pcrd_in_t             pixel,
	output logic                 done,
	output pcrd_out_t            ray,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VEC_W-1:0]     cfg_data
);

	localparam int MAG_W  = (PIXEL_BITS + 1 > SIZE_W) ? PIXEL_BITS + 1 : SIZE_W;
	localparam int NUM_W  = MAG_W + FRAC_BITS;
	localparam int PT_W   = NUM_W + TAN_W;
	localparam int T_W    = PT_W - TAN_FRAC;
	localparam int X_W    = T_W + 1;
	localparam int P_W    = LANE_W + X_W;
	localparam int C_W    = P_W + 2;
	localparam int NSTG   = $clog2(C_W);
	localparam int ROOT_W = NORM_W + 1;
	localparam int S_W    = 2 * ROOT_W;
	localparam int SQ_W   = 2 * NORM_W;
	localparam int FN_W   = NORM_W + OUT_FRAC + 1;
	localparam int QD_W   = OUT_FRAC + 1;
	localparam int LAT    = NUM_W + NSTG + ROOT_W + QD_W + 10;
	localparam int SB_DLY = NSTG + ROOT_W + QD_W + 3;
	localparam logic [PT_W-1:0]  ROUND = PT_W'(1) << (TAN_FRAC - 1);
	localparam logic [QD_W-1:0]  UNIT  = QD_W'(1) << OUT_FRAC;

	// configuration registers
	logic [SIZE_W-1:0] width_q, height_q;
	logic [TAN_W-1:0]  htan_q, vtan_q;
	logic [VEC_W-1:0]  up_q, right_q, aim_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			htan_q   <= HTAN_RST;
			vtan_q   <= VTAN_RST;
			up_q     <= UP_RST;
			right_q  <= RIGHT_RST;
			aim_q    <= AIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				REG_HORIZ_TAN:    htan_q   <= cfg_data[TAN_W-1:0];
				REG_VERT_TAN:     vtan_q   <= cfg_data[TAN_W-1:0];
				REG_UP_VECTOR:    up_q     <= cfg_data;
				REG_RIGHT_VECTOR: right_q  <= cfg_data;
				REG_AIM_VECTOR:   aim_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// in-flight marks
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	assign done = vld_q[LAT-1];

	// screen coordinate per axis: 0 is column, 1 is row
	logic [1:0][SIZE_W-1:0]    size;
	logic [1:0][PIXEL_BITS-1:0] pix;
	logic [1:0][TAN_W-1:0]     tanv;

	assign size[0] = (width_q == '0) ? SIZE_W'(1) : width_q;
	assign size[1] = (height_q == '0) ? SIZE_W'(1) : height_q;
	assign pix[0]  = PIXEL_BITS'(pixel.pixel_col);
	assign pix[1]  = PIXEL_BITS'(pixel.pixel_row);
	assign tanv[0] = htan_q;
	assign tanv[1] = vtan_q;

	logic signed [1:0][X_W-1:0] axis_s;

	genvar a, k, i;
	generate
		for (a = 0; a < 2; a++) begin : g_axis
			logic [MAG_W-1:0]  twice, sz;
			logic              neg;
			logic [NUM_W-1:0]  num_s1;
			logic              neg_s1;
			logic [NUM_W:0][SIZE_W-1:0] rem_c, den_c;
			logic [NUM_W:0][NUM_W-1:0]  num_c, quo_c;
			logic [PT_W-1:0]   prod;
			logic [T_W-1:0]    tmag_s;
			logic              neg_t;

			assign twice = MAG_W'({pix[a], 1'b0});
			assign sz    = MAG_W'(size[a]);
			assign neg   = twice < sz;

			always_ff @(posedge clk) begin
				num_s1 <= NUM_W'(neg ? (sz - twice) : (twice - sz)) << FRAC_BITS;
				neg_s1 <= neg;
			end

			assign rem_c[0] = '0;
			assign num_c[0] = num_s1;
			assign quo_c[0] = '0;
			assign den_c[0] = size[a];

			for (k = 0; k < NUM_W; k++) begin : g_cell
				pcrd_div_cell #(.REM_W(SIZE_W), .NUM_W(NUM_W), .Q_W(NUM_W)) u_cell (
					.clk      (clk),
					.rem      (rem_c[k]),
					.num      (num_c[k]),
					.quo      (quo_c[k]),
					.den      (den_c[k]),
					.rem_next (rem_c[k+1]),
					.num_next (num_c[k+1]),
					.quo_next (quo_c[k+1]),
					.den_next (den_c[k+1])
				);
			end

			pcrd_delay #(.WIDTH(1), .DEPTH(NUM_W + 1)) u_neg (
				.clk  (clk),
				.din  (neg_s1),
				.dout (neg_t)
			);

			assign prod = PT_W'(quo_c[NUM_W]) * PT_W'(tanv[a]);

			always_ff @(posedge clk) begin
				tmag_s <= T_W'((prod + ROUND) >> TAN_FRAC);
			end

			always_ff @(posedge clk) begin
				axis_s[a] <= neg_t ? -$signed({1'b0, tmag_s}) : $signed({1'b0, tmag_s});
			end
		end
	endgenerate

	// combined vector per lane
	logic signed [2:0][P_W-1:0] pu_s, pr_s;
	logic signed [2:0][C_W-1:0] aim_s, c_s;
	logic [2:0]                 neg_d;
	logic [2:0][C_W-1:0]        mag_d;
	logic [C_W-1:0]             word_d;

	generate
		for (i = 0; i < 3; i++) begin : g_lane
			logic signed [LANE_W-1:0] up_l, right_l, aim_l;
			logic signed [X_W-1:0]    ax_x, ax_y;
			logic signed [P_W-1:0]    up_p, right_p;

			assign up_l    = up_q[LANE_W*i +: LANE_W];
			assign right_l = right_q[LANE_W*i +: LANE_W];
			assign aim_l   = aim_q[LANE_W*i +: LANE_W];
			assign ax_x    = axis_s[0];
			assign ax_y    = axis_s[1];
			assign up_p    = up_l * ax_y;
			assign right_p = right_l * ax_x;

			always_ff @(posedge clk) begin
				pu_s[i]  <= up_p;
				pr_s[i]  <= right_p;
				aim_s[i] <= C_W'(aim_l) <<< FRAC_BITS;
				c_s[i]   <= C_W'($signed(pu_s[i])) + C_W'($signed(pr_s[i])) + aim_s[i];
				neg_d[i] <= c_s[i][C_W-1];
				mag_d[i] <= c_s[i][C_W-1] ? C_W'(-c_s[i]) : C_W'(c_s[i]);
			end
		end
	endgenerate

	assign word_d = mag_d[0] | mag_d[1] | mag_d[2];

	// sign and zero marks ride alongside to the output
	logic [2:0] neg_o;
	logic       zero_o;

	pcrd_delay #(.WIDTH(4), .DEPTH(SB_DLY)) u_side (
		.clk  (clk),
		.din  ({neg_d, word_d == '0}),
		.dout ({neg_o, zero_o})
	);

	// normalising shift cells
	logic [NSTG:0][C_W-1:0]      word_c;
	logic [NSTG:0][2:0][C_W-1:0] nmag_c;

	assign word_c[0] = word_d;
	assign nmag_c[0] = mag_d;

	generate
		for (k = 0; k < NSTG; k++) begin : g_norm
			pcrd_norm_cell #(.W(C_W), .SH(1 << (NSTG - 1 - k))) u_cell (
				.clk       (clk),
				.word      (word_c[k]),
				.mag       (nmag_c[k]),
				.word_next (word_c[k+1]),
				.mag_next  (nmag_c[k+1])
			);
		end
	endgenerate

	logic [2:0][NORM_W-1:0] m30;
	logic [2:0][SQ_W-1:0]   sq_s;
	logic [S_W-1:0]         sum_s;
	logic [2:0][NORM_W-1:0] m30_r;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			m30[j] = nmag_c[NSTG][j][C_W-1 -: NORM_W];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			sq_s[j] <= SQ_W'(m30[j]) * SQ_W'(m30[j]);
		end
		sum_s <= S_W'(sq_s[0]) + S_W'(sq_s[1]) + S_W'(sq_s[2]);
	end

	pcrd_delay #(.WIDTH(3 * NORM_W), .DEPTH(ROOT_W + 2)) u_mag (
		.clk  (clk),
		.din  (m30),
		.dout (m30_r)
	);

	// square root cells
	logic [ROOT_W:0][S_W-1:0]    rad_c;
	logic [ROOT_W:0][ROOT_W:0]   srem_c;
	logic [ROOT_W:0][ROOT_W-1:0] root_c;

	assign rad_c[0]  = sum_s;
	assign srem_c[0] = '0;
	assign root_c[0] = '0;

	generate
		for (k = 0; k < ROOT_W; k++) begin : g_sqrt
			pcrd_sqrt_cell #(.ROOT_W(ROOT_W)) u_cell (
				.clk       (clk),
				.rad       (rad_c[k]),
				.rem       (srem_c[k]),
				.root      (root_c[k]),
				.rad_next  (rad_c[k+1]),
				.rem_next  (srem_c[k+1]),
				.root_next (root_c[k+1])
			);
		end
	endgenerate

	// final division per lane
	logic [2:0][QD_W-1:0] dq;

	generate
		for (i = 0; i < 3; i++) begin : g_fdiv
			logic [FN_W-1:0] fnum_s;
			logic [ROOT_W-1:0] r_s;
			logic [QD_W:0][ROOT_W-1:0] rem_c, den_c;
			logic [QD_W:0][QD_W-1:0]   num_c, quo_c;

			always_ff @(posedge clk) begin
				fnum_s <= (FN_W'(m30_r[i]) << OUT_FRAC) + FN_W'(root_c[ROOT_W] >> 1);
				r_s    <= root_c[ROOT_W];
			end

			assign rem_c[0] = ROOT_W'(fnum_s >> QD_W);
			assign num_c[0] = fnum_s[QD_W-1:0];
			assign quo_c[0] = '0;
			assign den_c[0] = r_s;

			for (k = 0; k < QD_W; k++) begin : g_cell
				pcrd_div_cell #(.REM_W(ROOT_W), .NUM_W(QD_W), .Q_W(QD_W)) u_cell (
					.clk      (clk),
					.rem      (rem_c[k]),
					.num      (num_c[k]),
					.quo      (quo_c[k]),
					.den      (den_c[k]),
					.rem_next (rem_c[k+1]),
					.num_next (num_c[k+1]),
					.quo_next (quo_c[k+1]),
					.den_next (den_c[k+1])
				);
			end

			assign dq[i] = (quo_c[QD_W] > UNIT) ? UNIT : quo_c[QD_W];
		end
	endgenerate

	// output register
	logic [2:0][DIR_W-1:0] dir_v;
	pcrd_out_t             ray_q;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (zero_o) begin
				dir_v[j] = '0;
			end else if (neg_o[j]) begin
				dir_v[j] = DIR_W'(-$signed({1'b0, dq[j]}));
			end else begin
				dir_v[j] = DIR_W'({1'b0, dq[j]});
			end
		end
	end

	always_ff @(posedge clk) begin
		ray_q.dir_x       <= dir_v[0];
		ray_q.dir_y       <= dir_v[1];
		ray_q.dir_z       <= dir_v[2];
		ray_q.zero_length <= zero_o;
	end

	assign ray = ray_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("pixel did not produce a ray after the pipeline latency");

	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		done && ray.zero_length |-> ray.dir_x == '0 && ray.dir_y == '0 && ray.dir_z == '0)
		else $error("zero length ray with non-zero direction");

	a_nonzero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ray.zero_length |-> ray.dir_x != '0 || ray.dir_y != '0 || ray.dir_z != '0)
		else $error("non-zero vector gave a zero direction");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ray.dir_x <= 16'sd16384 && ray.dir_x >= -16'sd16384
			&& ray.dir_z <= 16'sd16384 && ray.dir_z >= -16'sd16384)
		else $error("direction component beyond unit length");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pinhole camera ray direction block.
//
// Pixels are queued by a stimulus process and presented by a clocked driver
// with random idle bursts. A predictor computes the unit direction for every
// accepted pixel under the camera set in force, and a clocked monitor compares
// each ray with the oldest prediction, field by field. The camera registers
// are rewritten between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module testbench;
	import pcrd_pkg::*;

	localparam int LATENCY = 89;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pcrd_in_t pixel = '0;
	logic done;
	pcrd_out_t ray;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VEC_W-1:0] cfg_data = '0;

	pinhole_camera_ray_direction u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .ray(ray), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// camera copy held by the predictor
	logic [SIZE_W-1:0] cam_width, cam_height;
	logic [TAN_W-1:0] cam_htan, cam_vtan;
	logic [VEC_W-1:0] cam_up, cam_right, cam_aim;

	pcrd_in_t pending_pixels[$];
	pcrd_out_t expected_rays[$];
	int error_count = 0;
	int rays_checked = 0;
	int zero_rays = 0;
	int config_writes = 0;
	bit idle_allowed = 1'b1;
	bit hold_pixels = 1'b0;
	int gap_left = 0;
	int quiet_cycles = 0;

	function automatic longint lane_value(logic [VEC_W-1:0] v, int lane);
		logic signed [LANE_W-1:0] s;
		s = v[lane*LANE_W +: LANE_W];
		return longint'(s);
	endfunction

	function automatic longint scaled_screen(logic [IN_PIX_W-1:0] p,
			logic [SIZE_W-1:0] size, logic [TAN_W-1:0] tan_q);
		longint unsigned s, twice, mag, q, t;
		bit neg;
		s = (size == 0) ? 1 : size;
		twice = 2 * longint'(p);
		neg = twice < s;
		mag = (neg ? (s - twice) : (twice - s)) << FRAC_BITS_DEF;
		q = mag / s;
		t = (q * tan_q + 2048) >> TAN_FRAC;
		return neg ? -longint'(t) : longint'(t);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic pcrd_out_t predict_ray(pcrd_in_t px);
		pcrd_out_t r;
		longint x, y, c;
		longint unsigned mag[3], mx, sum, root, d;
		bit neg[3];
		logic signed [DIR_W-1:0] comp[3];
		x = scaled_screen(px.pixel_col, cam_width, cam_htan);
		y = scaled_screen(px.pixel_row, cam_height, cam_vtan);
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			c = lane_value(cam_up, i) * y + lane_value(cam_right, i) * x
				+ lane_value(cam_aim, i) * (64'sd1 <<< FRAC_BITS_DEF);
			neg[i] = c < 0;
			mag[i] = neg[i] ? -c : c;
			if (mag[i] > mx) mx = mag[i];
		end
		r = '0;
		if (mx == 0) begin
			r.zero_length = 1'b1;
			return r;
		end
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
		root = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			d = ((mag[i] << OUT_FRAC) + (root >> 1)) / root;
			if (d > 16384) d = 16384;
			comp[i] = neg[i] ? -longint'(d) : longint'(d);
		end
		r.dir_x = comp[0];
		r.dir_y = comp[1];
		r.dir_z = comp[2];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// driver
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_rays.push_back(predict_ray(pixel));
		end
		if (start && busy) begin
			// pixel still waiting
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
			gap_left <= $urandom_range(0, 7);
			start <= 1'b0;
		end else if (!hold_pixels && pending_pixels.size() > 0) begin
			pixel <= pending_pixels.pop_front();
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (done) begin
			if (expected_rays.size() == 0) begin
				report_mismatch("ray with none outstanding", 1, 0);
			end else begin
				pcrd_out_t want;
				want = expected_rays.pop_front();
				if (ray.dir_x !== want.dir_x) report_mismatch("dir_x", ray.dir_x, want.dir_x);
				if (ray.dir_y !== want.dir_y) report_mismatch("dir_y", ray.dir_y, want.dir_y);
				if (ray.dir_z !== want.dir_z) report_mismatch("dir_z", ray.dir_z, want.dir_z);
				if (ray.zero_length !== want.zero_length)
					report_mismatch("zero_length", ray.zero_length, want.zero_length);
				rays_checked++;
				if (want.zero_length) zero_rays++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n
				|| (pending_pixels.size() == 0 && expected_rays.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic write_register(reg_idx_t idx, logic [VEC_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  cam_width = value[SIZE_W-1:0];
			REG_IMAGE_HEIGHT: cam_height = value[SIZE_W-1:0];
			REG_HORIZ_TAN:    cam_htan = value[TAN_W-1:0];
			REG_VERT_TAN:     cam_vtan = value[TAN_W-1:0];
			REG_UP_VECTOR:    cam_up = value;
			REG_RIGHT_VECTOR: cam_right = value;
			REG_AIM_VECTOR:   cam_aim = value;
			default: ;
		endcase
		config_writes++;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_pixels.size() > 0 || start || expected_rays.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [VEC_W-1:0] pack_vec(int x, int y, int z);
		logic [LANE_W-1:0] a, b, c;
		a = x; b = y; c = z;
		return {c, b, a};
	endfunction

	function automatic logic [VEC_W-1:0] random_vec();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
			1: return pack_vec(int'($urandom_range(0, 65535)), 0, 0);
			default: return pack_vec($urandom_range(0, 32767) - 16384,
				$urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384);
		endcase
	endfunction

	task automatic queue_random(int n, int max_pix);
		pcrd_in_t p;
		for (int i = 0; i < n; i++) begin
			p.pixel_col = $urandom_range(0, max_pix);
			p.pixel_row = $urandom_range(0, max_pix);
			pending_pixels.push_back(p);
		end
	endtask

	task automatic queue_pixel(int c, int r);
		pcrd_in_t p;
		p.pixel_col = c;
		p.pixel_row = r;
		pending_pixels.push_back(p);
	endtask

	initial begin
		cam_width = WIDTH_RST; cam_height = HEIGHT_RST;
		cam_htan = HTAN_RST; cam_vtan = VTAN_RST;
		cam_up = UP_RST; cam_right = RIGHT_RST; cam_aim = AIM_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset camera: corners, centre, beyond the image
		queue_pixel(0, 0); queue_pixel(4095, 4095); queue_pixel(360, 240);
		queue_pixel(719, 479); queue_pixel(4095, 0); queue_pixel(0, 4095);
		queue_pixel(2730, 1365); queue_pixel(1, 2048);
		drain();

		// extremes: zero size, max size, zero and max tangents, zero sum
		write_register(REG_IMAGE_WIDTH, 0);
		write_register(REG_IMAGE_HEIGHT, 8191);
		write_register(REG_HORIZ_TAN, 16'hFFFF);
		write_register(REG_VERT_TAN, 0);
		queue_pixel(0, 0); queue_pixel(4095, 4095); queue_pixel(1, 4095);
		drain();
		write_register(REG_AIM_VECTOR, 0);
		write_register(REG_UP_VECTOR, pack_vec(16'h7FFF, 16'h8000, 16'hFFFF));
		write_register(REG_RIGHT_VECTOR, 0);
		write_register(REG_IMAGE_WIDTH, 4096);
		queue_pixel(0, 0); queue_pixel(2048, 100); queue_pixel(4095, 4095);
		drain();
		write_register(REG_RIGHT_VECTOR, pack_vec(-16384, 16384, 32767));
		write_register(REG_AIM_VECTOR, 48'hFFFF_FFFF_FFFF);
		write_register(REG_VERT_TAN, 16'hFFFF);
		write_register(REG_IMAGE_HEIGHT, 1);
		queue_pixel(0, 0); queue_pixel(4095, 1); queue_pixel(2048, 4095);
		queue_pixel(1234, 2345);
		drain();

		// random phases with random camera; half the pixels span the full range, half stay within the width
		for (int ph = 0; ph < 16; ph++) begin
			int w;
			w = (ph % 4 == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
			write_register(REG_IMAGE_WIDTH, w);
			write_register(REG_IMAGE_HEIGHT, $urandom_range(0, 8191));
			write_register(REG_HORIZ_TAN, $urandom_range(0, 65535));
			write_register(REG_VERT_TAN, $urandom_range(0, 65535));
			write_register(REG_UP_VECTOR, random_vec());
			write_register(REG_RIGHT_VECTOR, random_vec());
			write_register(REG_AIM_VECTOR, random_vec());
			if (ph >= 13) idle_allowed = 1'b0;
			queue_random(50, 4095);
			queue_random(50, (w > 4095) ? 4095 : w);
			if (ph == 5) begin
				// sender holds off until every ray has come back
				while (pending_pixels.size() > 50) @(posedge clk);
				hold_pixels = 1'b1;
				while (start || expected_rays.size() > 0) @(posedge clk);
				hold_pixels = 1'b0;
			end
			drain();
		end

		$display("covered %0d rays (%0d zero length) over %0d register writes",
			rays_checked, zero_rays, config_writes);
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/pcrd_pkg.sv
rtl/pcrd_delay.sv
rtl/pcrd_div_cell.sv
rtl/pcrd_sqrt_cell.sv
rtl/pcrd_norm_cell.sv
rtl/pinhole_camera_ray_direction.sv
test/testbench.sv
